// ===== rtl/billboard_glyph_quad_generator_core_assert.svh =====
// Assertion shorthands used by bgq_back.
`ifndef BILLBOARD_GLYPH_QUAD_GENERATOR_CORE_ASSERT_SVH
`define BILLBOARD_GLYPH_QUAD_GENERATOR_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BGQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BGQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bgq_pkg.sv =====
`default_nettype none
package bgq_pkg;

  localparam logic [7:0]  CHAR_FIRST = 8'd32;
  localparam logic [7:0]  CHAR_LAST  = 8'd126;
  localparam logic [16:0] UV_ONE     = 17'h10000;
  localparam int unsigned DIV_STEPS  = 24;
  localparam int unsigned MUL_STEPS  = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] STEP_CURSOR = 3'd0;
  localparam logic [2:0] STEP_R_POS  = 3'd1;
  localparam logic [2:0] STEP_R_NEG  = 3'd2;
  localparam logic [2:0] STEP_U_POS  = 3'd3;
  localparam logic [2:0] STEP_U_NEG  = 3'd4;

  typedef struct packed {
    logic [7:0]         char_code;
    logic               first_of_string;
    logic               start_batch;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
    logic [30:0]        glyph_scale;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [1:0]         corner;
    logic [15:0]        vertex_number;
    logic               last_of_glyph;
    logic               overflow;
  } vertex_t;

  typedef struct packed {
    logic [7:0]         atlas_columns;
    logic [7:0]         atlas_rows;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    atlas_columns: 8'd16,
    atlas_rows:    8'd16,
    right_x:       32'sh0001_0000,
    right_y:       32'sh0,
    right_z:       32'sh0,
    up_x:          32'sh0,
    up_y:          32'sh0001_0000,
    up_z:          32'sh0
  };

  typedef struct packed {
    logic               first_of_string;
    logic               start_batch;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
    logic [30:0]        glyph_scale;
    logic [16:0]        u0;
    logic [16:0]        u1;
    logic [16:0]        v0;
    logic [16:0]        v1;
  } job_t;

  typedef enum logic [2:0] {
    REG_ATLAS_COLUMNS,
    REG_ATLAS_ROWS,
    REG_RIGHT_X,
    REG_RIGHT_Y,
    REG_RIGHT_Z,
    REG_UP_X,
    REG_UP_Y,
    REG_UP_Z
  } cfg_reg_e;

  typedef enum logic [1:0] {F_IDLE, F_LOAD, F_DIV, F_PUSH} front_state_e;

  typedef enum logic [2:0] {OP_CELL, OP_U0, OP_U1, OP_V0, OP_V1} div_op_e;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_EMIT} back_state_e;

endpackage
`default_nettype wire

// ===== rtl/bgq_front.sv =====
`default_nettype none
module bgq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bgq_pkg::cfg_t  cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bgq_pkg::item_t in_item_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output bgq_pkg::job_t  job_o
);
  import bgq_pkg::*;

  front_state_e state_q, state_d;
  div_op_e      op_q;
  logic [4:0]   step_q;
  logic [23:0]  quo_q;
  logic [7:0]   rem_q;
  logic [7:0]   dvs_q;
  logic [7:0]   col_q, row_q;
  item_t        item_q;
  logic [16:0]  u0_q, u1_q, v0_q, v1_q;

  logic         accept, div_last, code_ok;
  logic [15:0]  cells;
  logic [8:0]   rem_sh, rem_nx;
  logic         ge;
  logic [23:0]  quo_nx;
  logic [23:0]  load_dividend;
  logic [7:0]   load_dvs;

  assign cells   = cfg_i.atlas_columns * cfg_i.atlas_rows;
  assign code_ok = (cfg_i.atlas_columns != 8'd0) && (cfg_i.atlas_rows != 8'd0) &&
                   (in_item_i.char_code >= CHAR_FIRST) &&
                   (in_item_i.char_code <= CHAR_LAST) &&
                   ({8'd0, in_item_i.char_code} < cells);

  // one restoring division step per cycle
  assign rem_sh   = {rem_q, quo_q[23]};
  assign ge       = rem_sh >= {1'b0, dvs_q};
  assign rem_nx   = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  assign quo_nx   = {quo_q[22:0], ge};
  assign div_last = (step_q == 5'(DIV_STEPS - 1));

  always_comb begin
    load_dividend = {16'd0, item_q.char_code};
    load_dvs      = cfg_i.atlas_columns;
    case (op_q)
      OP_CELL: begin
        load_dividend = {16'd0, item_q.char_code};
        load_dvs      = cfg_i.atlas_columns;
      end
      OP_U0: begin
        load_dividend = {col_q, 16'd0};
        load_dvs      = cfg_i.atlas_columns;
      end
      OP_U1: begin
        load_dividend = {col_q + 8'd1, 16'd0};
        load_dvs      = cfg_i.atlas_columns;
      end
      OP_V0: begin
        load_dividend = {row_q, 16'd0};
        load_dvs      = cfg_i.atlas_rows;
      end
      OP_V1: begin
        load_dividend = {row_q + 8'd1, 16'd0};
        load_dvs      = cfg_i.atlas_rows;
      end
      default: begin
        load_dividend = {16'd0, item_q.char_code};
        load_dvs      = cfg_i.atlas_columns;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = code_ok ? F_LOAD : F_PUSH;
      end
      F_LOAD: state_d = F_DIV;
      F_DIV: begin
        if (div_last) state_d = (op_q == OP_V1) ? F_PUSH : F_LOAD;
      end
      F_PUSH: begin
        if (job_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == F_IDLE);
    job_valid_o = (state_q == F_PUSH);
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= OP_CELL;
      step_q  <= 5'd0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        op_q <= OP_CELL;
      end else if (state_q == F_DIV && div_last && op_q != OP_V1) begin
        op_q <= div_op_e'(op_q + 3'd1);
      end
      if (state_q == F_LOAD) begin
        step_q <= 5'd0;
      end else if (state_q == F_DIV) begin
        step_q <= step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      u0_q   <= 17'd0;
      u1_q   <= UV_ONE;
      v0_q   <= 17'd0;
      v1_q   <= UV_ONE;
    end
    if (state_q == F_LOAD) begin
      quo_q <= load_dividend;
      rem_q <= 8'd0;
      dvs_q <= load_dvs;
    end else if (state_q == F_DIV) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx[7:0];
      if (div_last) begin
        case (op_q)
          OP_CELL: begin
            row_q <= quo_nx[7:0];
            col_q <= rem_nx[7:0];
          end
          OP_U0:   u0_q <= quo_nx[16:0];
          OP_U1:   u1_q <= quo_nx[16:0];
          OP_V0:   v0_q <= quo_nx[16:0];
          OP_V1:   v1_q <= quo_nx[16:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    job_o.first_of_string = item_q.first_of_string;
    job_o.start_batch     = item_q.start_batch;
    job_o.anchor_x        = item_q.anchor_x;
    job_o.anchor_y        = item_q.anchor_y;
    job_o.anchor_z        = item_q.anchor_z;
    job_o.glyph_scale     = item_q.glyph_scale;
    job_o.u0              = u0_q;
    job_o.u1              = u1_q;
    job_o.v0              = v0_q;
    job_o.v1              = v1_q;
  end

endmodule
`default_nettype wire

// ===== rtl/bgq_fifo.sv =====
`default_nettype none
module bgq_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  bgq_pkg::job_t push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output bgq_pkg::job_t pop_data_o
);
  import bgq_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/bgq_back.sv =====
`default_nettype none
module bgq_back #(
  parameter int unsigned VERTEX_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bgq_pkg::cfg_t    cfg_i,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  bgq_pkg::job_t    job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bgq_pkg::vertex_t out_vert_o
);
  import bgq_pkg::*;

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [30:0] cursor_q;
  logic [VERTEX_BITS-1:0] vcnt_q, vcnt_nx;
  logic        wrap_q;
  logic [2:0]  step_q;
  logic [1:0]  corner_q;
  logic        out_valid_q;
  vertex_t     out_q;

  logic signed [63:0] prod_q [3];
  logic signed [31:0] term_q [MUL_STEPS][3];
  logic signed [31:0] mul_a  [3];
  logic signed [31:0] mul_b;
  logic signed [31:0] anchor [3];
  logic signed [31:0] vert   [3];
  logic signed [31:0] quarter;
  logic [2:0]  term_idx;
  logic [31:0] cursor_sum;
  logic [30:0] cursor_nx;
  logic [VERTEX_BITS+15:0] vnum_ext;
  logic        pop, out_load, mul_last, emit_last;

  function automatic logic signed [31:0] sat_q16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
    else if (s < -64'sd2147483648) return 32'sh8000_0000;
    else return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -35'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  assign quarter  = {3'd0, job_q.glyph_scale[30:2]};
  assign term_idx = step_q - 3'd1;
  assign mul_last = (step_q == 3'(MUL_STEPS));
  assign anchor[0] = job_q.anchor_x;
  assign anchor[1] = job_q.anchor_y;
  assign anchor[2] = job_q.anchor_z;

  // right vector for the cursor and right terms, up vector for the rest
  always_comb begin
    mul_a[0] = (step_q < STEP_U_POS) ? cfg_i.right_x : cfg_i.up_x;
    mul_a[1] = (step_q < STEP_U_POS) ? cfg_i.right_y : cfg_i.up_y;
    mul_a[2] = (step_q < STEP_U_POS) ? cfg_i.right_z : cfg_i.up_z;
    case (step_q)
      STEP_CURSOR: mul_b = {1'b0, cursor_q};
      STEP_R_POS:  mul_b = quarter;
      STEP_R_NEG:  mul_b = -quarter;
      STEP_U_POS:  mul_b = quarter;
      STEP_U_NEG:  mul_b = -quarter;
      default:     mul_b = quarter;
    endcase
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vert[a] = sat35(35'(anchor[a]) + 35'(term_q[STEP_CURSOR][a]) +
                      35'(corner_q[0] ? term_q[STEP_R_POS][a] : term_q[STEP_R_NEG][a]) +
                      35'(corner_q[1] ? term_q[STEP_U_NEG][a] : term_q[STEP_U_POS][a]));
    end
  end

  assign cursor_sum = {1'b0, cursor_q} + {2'd0, job_q.glyph_scale[30:1]};
  assign cursor_nx  = cursor_sum[31] ? 31'h7FFF_FFFF : cursor_sum[30:0];
  assign vcnt_nx    = vcnt_q + VERTEX_BITS'(1);
  assign vnum_ext   = {16'd0, vcnt_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) state_d = B_MUL;
      end
      B_MUL: begin
        if (mul_last) state_d = B_EMIT;
      end
      B_EMIT: begin
        if (emit_last) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (state_q == B_IDLE);
    out_valid_o = out_valid_q;
    out_vert_o  = out_q;
  end

  assign pop       = job_valid_i && job_ready_o;
  assign out_load  = (state_q == B_EMIT) && (!out_valid_q || out_ready_i);
  assign emit_last = out_load && (corner_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= 3'd0;
      corner_q    <= 2'd0;
      cursor_q    <= 31'd0;
      vcnt_q      <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        step_q   <= 3'd0;
        corner_q <= 2'd0;
        if (job_i.first_of_string) cursor_q <= 31'd0;
        if (job_i.start_batch) begin
          vcnt_q <= '0;
          wrap_q <= 1'b0;
        end
      end else if (state_q == B_MUL) begin
        step_q <= step_q + 3'd1;
      end
      if (out_load) begin
        corner_q <= corner_q + 2'd1;
        vcnt_q   <= vcnt_nx;
        if (vcnt_nx == '0) wrap_q <= 1'b1;
        if (corner_q == 2'd3) cursor_q <= cursor_nx;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) job_q <= job_i;
    if (state_q == B_MUL) begin
      for (int a = 0; a < 3; a++) begin
        if (step_q < 3'(MUL_STEPS)) prod_q[a] <= mul_a[a] * mul_b;
        if (step_q != STEP_CURSOR) term_q[term_idx][a] <= sat_q16(prod_q[a]);
      end
    end
    if (out_load) begin
      out_q.vert_x        <= vert[0];
      out_q.vert_y        <= vert[1];
      out_q.vert_z        <= vert[2];
      out_q.tex_u         <= corner_q[0] ? job_q.u1 : job_q.u0;
      out_q.tex_v         <= corner_q[1] ? job_q.v1 : job_q.v0;
      out_q.corner        <= corner_q;
      out_q.vertex_number <= vnum_ext[15:0];
      out_q.last_of_glyph <= (corner_q == 2'd3);
      out_q.overflow      <= wrap_q;
    end
  end

`include "billboard_glyph_quad_generator_core_assert.svh"

  `BGQ_ASSERT_SAME(a_idle_holds_last, clk_i, rst_ni, state_q == B_IDLE && out_valid_q, out_q.last_of_glyph, "idle with a vertex other than the last of its glyph pending")
  `BGQ_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, emit_last, state_q == B_IDLE, "fourth vertex did not end the glyph")
  `BGQ_ASSERT_NEXT(a_wrap_sticky, clk_i, rst_ni, wrap_q && !(pop && job_i.start_batch), wrap_q, "overflow flag dropped without a batch start")

endmodule
`default_nettype wire

// ===== rtl/billboard_glyph_quad_generator_core.sv =====
`default_nettype none
// Billboard glyph quad generator: each accepted character item yields four vertex items
// (corners TL, TR, BL, BR) of a camera-facing quad, with texture coordinates from a grid
// font atlas. In the front end, a character item that maps to an atlas cell passes
// through the one-bit-per-cycle divider, which forms the cell and its four texture
// edges in turn; a character outside the atlas skips the divider. The back end steps
// its three shared multipliers through the cursor and corner products and then emits
// the four vertex items. A two-entry queue lets the front end work on the next
// character while the back end emits. Both ends read the configuration live, so write
// it only while no item is in flight.
module billboard_glyph_quad_generator_core #(
  parameter int unsigned VERTEX_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bgq_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bgq_pkg::vertex_t out_vert_o
);
  import bgq_pkg::*;

  cfg_t cfg_q;
  job_t push_job, pop_job;
  logic push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ATLAS_COLUMNS: cfg_q.atlas_columns <= cfg_wdata_i[7:0];
        REG_ATLAS_ROWS:    cfg_q.atlas_rows    <= cfg_wdata_i[7:0];
        REG_RIGHT_X:       cfg_q.right_x       <= cfg_wdata_i;
        REG_RIGHT_Y:       cfg_q.right_y       <= cfg_wdata_i;
        REG_RIGHT_Z:       cfg_q.right_z       <= cfg_wdata_i;
        REG_UP_X:          cfg_q.up_x          <= cfg_wdata_i;
        REG_UP_Y:          cfg_q.up_y          <= cfg_wdata_i;
        REG_UP_Z:          cfg_q.up_z          <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bgq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  bgq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  bgq_back #(
    .VERTEX_BITS (VERTEX_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_vert_o  (out_vert_o)
  );

endmodule
`default_nettype wire
